// ----- hdl/nearest_site_search_assert.svh -----
// Assertion macros shared by the nearest site search RTL.
// Expects clk and arst_n in scope at the point of use.
`ifndef NEAREST_SITE_SEARCH_ASSERT_SVH
`define NEAREST_SITE_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nearest_site_search: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nearest_site_search: assertion failed");

`endif

// ----- hdl/nss_pkg.sv -----
// Types and codes for the nearest site search block.
// No dependencies; imported by nearest_site_search and its testbench.
package nss_pkg;

	localparam int COORD_W = 24;
	localparam int INDEX_W = 10;
	localparam int DIST_W  = 50;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_FOUND  = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic                      command;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} req_word_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [INDEX_W-1:0]        site_index;
		logic signed [COORD_W-1:0] site_x;
		logic signed [COORD_W-1:0] site_y;
		logic [DIST_W-1:0]         distance_squared;
	} rsp_word_t;

endpackage

// ----- hdl/nearest_site_search.sv -----
// Nearest site search: site table in a memory, linear scan for the closest site.
// Depends on nss_pkg and nearest_site_search_assert.svh.
//
//  channel  handshake              word        direction
//  req      req_valid/req_ready    req_word    into block (append or query)
//  rsp      rsp_valid/rsp_ready    rsp_word    out of block (one per request)
//
// Append and empty-table query: result registered in the cycle after acceptance.
// Query with N stored sites: a scan of all N sites, then the result; the single
// memory read port and the distance pipeline take one site per cycle.
// Reset clears the site count and all control; the table is not cleared.
// req_ready is low during a scan and while an undelivered result blocks the
// output register.
module nearest_site_search
	import nss_pkg::*;
#(
	parameter int MAX_SITES  = 1024,
	parameter int COORD_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp_word
);

	localparam int IDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int CNT_W = $clog2(MAX_SITES + 1);
	localparam int CW    = COORD_BITS;
	localparam int DW    = COORD_BITS + 1;
	localparam int SQW   = 2 * DW;
	localparam int SUMW  = SQW + 1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

	state_t state_q;

	logic [CNT_W-1:0]     site_count_q;
	logic [IDX_W-1:0]     rd_addr_q;
	logic [IDX_W-1:0]     last_idx_q;
	logic signed [CW-1:0] qx_q;
	logic signed [CW-1:0] qy_q;

	logic [2*CW-1:0] site_mem [MAX_SITES];

	logic                 rsp_valid_q;
	rsp_word_t            rsp_word_q;
	logic [SUMW-1:0]      best_d_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic signed [CW-1:0] best_x_q;
	logic signed [CW-1:0] best_y_q;

	// scan pipeline
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3, idx_s4;
	logic [2*CW-1:0]      rd_data_s1;
	logic signed [CW-1:0] x_s2, x_s3, x_s4;
	logic signed [CW-1:0] y_s2, y_s3, y_s4;
	logic [DW-1:0]        dx_s2, dy_s2, dy_s3;
	logic [SQW-1:0]       sx_s3, sx_s4, sy_s4;

	logic                 rsp_free;
	logic                 req_fire;
	logic                 table_full;
	logic                 rd_en;
	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;
	logic signed [CW-1:0] mem_x_s1;
	logic signed [CW-1:0] mem_y_s1;
	logic signed [DW-1:0] dx_raw;
	logic signed [DW-1:0] dy_raw;
	logic [SUMW-1:0]      sum_d;
	logic                 take_best;
	logic                 last_s4;

	assign rsp_free   = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == S_IDLE) && rsp_free;
	assign req_fire   = req_valid && req_ready;
	assign table_full = (site_count_q == CNT_W'(MAX_SITES));
	assign rd_en      = (state_q == S_SCAN);
	assign rsp_valid  = rsp_valid_q;
	assign rsp_word   = rsp_word_q;

	// take the low COORD_BITS of the field as two's complement
	assign in_x = CW'($unsigned(req_word.coord_x));
	assign in_y = CW'($unsigned(req_word.coord_y));

	assign mem_x_s1 = rd_data_s1[2*CW-1:CW];
	assign mem_y_s1 = rd_data_s1[CW-1:0];
	assign dx_raw   = DW'(mem_x_s1) - DW'(qx_q);
	assign dy_raw   = DW'(mem_y_s1) - DW'(qy_q);

	assign sum_d     = SUMW'(sx_s4) + SUMW'(sy_s4);
	// first site always seeds the best; later ones must be strictly closer
	assign take_best = vld_s4 && ((idx_s4 == '0) || (sum_d < best_d_q));
	assign last_s4   = vld_s4 && (idx_s4 == last_idx_q);

	always_ff @(posedge clk) begin
		if (req_fire && req_word.command == CMD_APPEND && !table_full) begin
			site_mem[site_count_q[IDX_W-1:0]] <= {in_x, in_y};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= site_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q;
		idx_s2 <= idx_s1;
		x_s2   <= mem_x_s1;
		y_s2   <= mem_y_s1;
		dx_s2  <= dx_raw[DW-1] ? DW'(-dx_raw) : DW'(dx_raw);
		dy_s2  <= dy_raw[DW-1] ? DW'(-dy_raw) : DW'(dy_raw);
		idx_s3 <= idx_s2;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		sx_s3  <= SQW'(dx_s2) * SQW'(dx_s2);
		dy_s3  <= dy_s2;
		idx_s4 <= idx_s3;
		x_s4   <= x_s3;
		y_s4   <= y_s3;
		sx_s4  <= sx_s3;
		sy_s4  <= SQW'(dy_s3) * SQW'(dy_s3);
		if (take_best) begin
			best_d_q   <= sum_d;
			best_idx_q <= idx_s4;
			best_x_q   <= x_s4;
			best_y_q   <= y_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			site_count_q <= '0;
			rsp_valid_q  <= 1'b0;
			rd_addr_q    <= '0;
			last_idx_q   <= '0;
			qx_q         <= '0;
			qy_q         <= '0;
			rsp_word_q   <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						rsp_word_q <= '0;
						if (req_word.command == CMD_APPEND) begin
							rsp_valid_q <= 1'b1;
							if (table_full) begin
								rsp_word_q.status <= ST_FULL;
							end else begin
								rsp_word_q.status     <= ST_STORED;
								rsp_word_q.site_index <= INDEX_W'(site_count_q);
								site_count_q          <= site_count_q + 1'b1;
							end
						end else if (site_count_q == '0) begin
							rsp_valid_q       <= 1'b1;
							rsp_word_q.status <= ST_EMPTY;
						end else begin
							qx_q       <= in_x;
							qy_q       <= in_y;
							rd_addr_q  <= '0;
							last_idx_q <= IDX_W'(site_count_q - 1'b1);
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_addr_q == last_idx_q) begin
						state_q <= S_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (last_s4) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold the result until the output register frees up
					if (rsp_free) begin
						rsp_valid_q                 <= 1'b1;
						rsp_word_q.status           <= ST_FOUND;
						rsp_word_q.site_index       <= INDEX_W'(best_idx_q);
						rsp_word_q.site_x           <= COORD_W'(best_x_q);
						rsp_word_q.site_y           <= COORD_W'(best_y_q);
						rsp_word_q.distance_squared <= DIST_W'(best_d_q);
						state_q                     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "nearest_site_search_assert.svh"

	`NSS_ASSERT_NEXT(a_append_counts,
		req_fire && req_word.command == CMD_APPEND && !table_full,
		rsp_valid && site_count_q == $past(site_count_q) + 1'b1)

	`NSS_ASSERT_SAME(a_count_bound, 1'b1, site_count_q <= CNT_W'(MAX_SITES))

	`NSS_ASSERT_SAME(a_idle_pipe_empty, state_q == S_IDLE,
		!vld_s1 && !vld_s2 && !vld_s3 && !vld_s4)

	`NSS_ASSERT_NEXT(a_last_site_done, last_s4, state_q == S_DONE)

endmodule

// ----- verif/nearest_site_search_tb.sv -----
// Self-checking testbench for nearest_site_search: site appends and nearest-site queries.
// Drives the block through valid/ready with random idling and checks each response word.
// Depends on nss_pkg and the nearest_site_search RTL.
module nearest_site_search_tb
	import nss_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SITE_CAP = 1024;
	localparam int X_MAX = 8388607;
	localparam int X_MIN = -8388608;
	localparam int QUERY_PCT = 40;
	localparam int HOLD_CYCLES = 1500;
	localparam int WATCHDOG_LIMIT = 12000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		req_word_t word;
		bit        typed;
		rsp_word_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_word_t req_word;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_word_t rsp_word;

	// predictor state: sites stored so far
	logic signed [COORD_W-1:0] sites_x [SITE_CAP];
	logic signed [COORD_W-1:0] sites_y [SITE_CAP];
	int                        sites_held = 0;

	rsp_word_t awaited_results[$];
	dir_row_t  dir_rows[$];
	int        mismatch_count = 0;
	int        stall_run = 0;
	int        send_idle = 0;
	int        recv_stall = 0;
	bit        pressure_armed = 1'b0;
	bit        pressure_done = 1'b0;

	nearest_site_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_word (rsp_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic req_word_t mk_req(logic cmd, int x, int y);
		req_word_t r;
		r.command = cmd;
		r.coord_x = x[COORD_W-1:0];
		r.coord_y = y[COORD_W-1:0];
		return r;
	endfunction

	function automatic rsp_word_t mk_rsp(logic [1:0] st, int idx, int x, int y, longint d);
		rsp_word_t r;
		r.status = st;
		r.site_index = idx[INDEX_W-1:0];
		r.site_x = x[COORD_W-1:0];
		r.site_y = y[COORD_W-1:0];
		r.distance_squared = d[DIST_W-1:0];
		return r;
	endfunction

	// Append to the site list, or scan it for the first site at the least distance.
	function automatic rsp_word_t nearest_or_store(req_word_t w);
		rsp_word_t r;
		longint    best_d;
		longint    d;
		longint    dx;
		longint    dy;
		int        best;
		r = '0;
		if (w.command == CMD_APPEND) begin
			if (sites_held >= SITE_CAP) begin
				r.status = ST_FULL;
			end else begin
				sites_x[sites_held] = w.coord_x;
				sites_y[sites_held] = w.coord_y;
				r.status = ST_STORED;
				r.site_index = sites_held[INDEX_W-1:0];
				sites_held++;
			end
		end else if (sites_held == 0) begin
			r.status = ST_EMPTY;
		end else begin
			best = 0;
			best_d = -1;
			for (int i = 0; i < sites_held; i++) begin
				dx = longint'($signed(w.coord_x)) - longint'($signed(sites_x[i]));
				dy = longint'($signed(w.coord_y)) - longint'($signed(sites_y[i]));
				d = dx * dx + dy * dy;
				// strictly smaller only: ties keep the lower index
				if (best_d < 0 || d < best_d) begin
					best_d = d;
					best = i;
				end
			end
			r.status = ST_FOUND;
			r.site_index = best[INDEX_W-1:0];
			r.site_x = sites_x[best];
			r.site_y = sites_y[best];
			r.distance_squared = best_d[DIST_W-1:0];
		end
		return r;
	endfunction

	function automatic int edge_coord();
		case ($urandom_range(4))
			0: return X_MAX;
			1: return X_MIN;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic req_word_t random_req(int query_pct);
		req_word_t r;
		int        mode;
		int        k;
		r.command = ($urandom_range(99) < query_pct) ? CMD_QUERY : CMD_APPEND;
		r.coord_x = COORD_W'($urandom);
		r.coord_y = COORD_W'($urandom);
		mode = $urandom_range(9);
		if (mode == 5 || mode == 6) begin
			// cluster near the origin to make ties and duplicates
			r.coord_x = COORD_W'($urandom_range(32) - 16);
			r.coord_y = COORD_W'($urandom_range(32) - 16);
		end else if (mode == 7) begin
			r.coord_x = COORD_W'(edge_coord());
			r.coord_y = COORD_W'(edge_coord());
		end else if (mode >= 8 && sites_held > 0) begin
			k = $urandom_range(sites_held - 1);
			r.coord_x = sites_x[k];
			r.coord_y = sites_y[k];
			if (mode == 8) begin
				r.coord_x = COORD_W'(r.coord_x + $urandom_range(6) - 3);
				r.coord_y = COORD_W'(r.coord_y + $urandom_range(6) - 3);
			end
		end
		return r;
	endfunction

	task automatic add_row(req_word_t w, bit typed, rsp_word_t want);
		dir_row_t row;
		row.word = w;
		row.typed = typed;
		row.want = want;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// Offer one word; leave valid high so a back-to-back word needs no lowering.
	task automatic send_word(req_word_t w, bit typed, rsp_word_t want);
		rsp_word_t predicted;
		int        gap;
		gap = 0;
		while ($urandom_range(99) < send_idle)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do @(posedge clk); while (req_ready !== 1'b1);
		predicted = nearest_or_store(w);
		awaited_results.insert(awaited_results.size(), typed ? want : predicted);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	task automatic run_phase(int count, int idle_pct, int stall_pct, int query_pct);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		repeat (count) send_word(random_req(query_pct), 1'b0, '0);
		drain_results();
	endtask

	// receiver: random stalls, plus one long hold-off when armed
	initial begin
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pressure_armed && !pressure_done) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				pressure_done = 1'b1;
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin : check_results
		rsp_word_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected response: st=%0d idx=%0d x=%0d y=%0d d=%0d",
						rsp_word.status, rsp_word.site_index, rsp_word.site_x,
						rsp_word.site_y, rsp_word.distance_squared);
			end else begin
				want = awaited_results.pop_front();
				if (rsp_word.status !== want.status
						|| rsp_word.site_index !== want.site_index
						|| rsp_word.site_x !== want.site_x
						|| rsp_word.site_y !== want.site_y
						|| rsp_word.distance_squared !== want.distance_squared) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want st=%0d idx=%0d x=%0d y=%0d d=%0d, %s",
							want.status, want.site_index, want.site_x, want.site_y,
							want.distance_squared,
							$sformatf("got st=%0d idx=%0d x=%0d y=%0d d=%0d",
								rsp_word.status, rsp_word.site_index, rsp_word.site_x,
								rsp_word.site_y, rsp_word.distance_squared));
				end
			end
		end
		if ((req_valid === 1'b1 && req_ready === 1'b1)
				|| (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
			stall_run = 0;
		end else begin
			stall_run++;
			if (stall_run >= WATCHDOG_LIMIT) begin
				$display("nearest_site_search_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_word = '0;

		// queries on the empty list first, then corners, ties and duplicates
		add_row(mk_req(CMD_QUERY, 0, 0), 1'b1, mk_rsp(ST_EMPTY, 0, 0, 0, 0));
		add_row(mk_req(CMD_QUERY, X_MAX, X_MIN), 1'b1, mk_rsp(ST_EMPTY, 0, 0, 0, 0));
		add_row(mk_req(CMD_QUERY, -1, -1), 1'b1, mk_rsp(ST_EMPTY, 0, 0, 0, 0));
		add_row(mk_req(CMD_APPEND, X_MAX, X_MAX), 1'b1, mk_rsp(ST_STORED, 0, 0, 0, 0));
		add_row(mk_req(CMD_QUERY, X_MIN, X_MIN), 1'b0, '0);
		add_row(mk_req(CMD_APPEND, X_MIN, X_MIN), 1'b1, mk_rsp(ST_STORED, 1, 0, 0, 0));
		add_row(mk_req(CMD_APPEND, X_MAX, X_MIN), 1'b1, mk_rsp(ST_STORED, 2, 0, 0, 0));
		add_row(mk_req(CMD_APPEND, X_MIN, X_MAX), 1'b1, mk_rsp(ST_STORED, 3, 0, 0, 0));
		add_row(mk_req(CMD_QUERY, X_MIN, X_MIN), 1'b1,
			mk_rsp(ST_FOUND, 1, X_MIN, X_MIN, 0));
		add_row(mk_req(CMD_QUERY, X_MAX, X_MIN), 1'b1,
			mk_rsp(ST_FOUND, 2, X_MAX, X_MIN, 0));
		add_row(mk_req(CMD_QUERY, 0, 0), 1'b0, '0);
		add_row(mk_req(CMD_APPEND, 0, 0), 1'b1, mk_rsp(ST_STORED, 4, 0, 0, 0));
		add_row(mk_req(CMD_APPEND, 1, 0), 1'b1, mk_rsp(ST_STORED, 5, 0, 0, 0));
		add_row(mk_req(CMD_APPEND, -1, 0), 1'b1, mk_rsp(ST_STORED, 6, 0, 0, 0));
		add_row(mk_req(CMD_APPEND, 0, 1), 1'b1, mk_rsp(ST_STORED, 7, 0, 0, 0));
		add_row(mk_req(CMD_APPEND, 0, 0), 1'b1, mk_rsp(ST_STORED, 8, 0, 0, 0));
		add_row(mk_req(CMD_QUERY, 0, 0), 1'b1, mk_rsp(ST_FOUND, 4, 0, 0, 0));
		add_row(mk_req(CMD_QUERY, 0, -1), 1'b0, '0);
		add_row(mk_req(CMD_QUERY, 1, 1), 1'b0, '0);
		add_row(mk_req(CMD_QUERY, X_MIN, X_MAX), 1'b1,
			mk_rsp(ST_FOUND, 3, X_MIN, X_MAX, 0));
		add_row(mk_req(CMD_APPEND, -1, -1), 1'b1, mk_rsp(ST_STORED, 9, 0, 0, 0));
		add_row(mk_req(CMD_QUERY, -1, -1), 1'b1, mk_rsp(ST_FOUND, 9, -1, -1, 0));
		add_row(mk_req(CMD_QUERY, X_MIN, 0), 1'b0, '0);
		add_row(mk_req(CMD_QUERY, X_MAX, X_MAX), 1'b1,
			mk_rsp(ST_FOUND, 0, X_MAX, X_MAX, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
		drain_results();

		run_phase(120, 0, 0, QUERY_PCT);
		run_phase(120, 78, 0, QUERY_PCT);
		run_phase(120, 0, 78, QUERY_PCT);
		run_phase(120, 25, 25, QUERY_PCT);

		// hold the receiver off while words keep coming
		pressure_armed <= 1'b1;
		run_phase(60, 0, 0, QUERY_PCT);

		// query-heavy tail over the grown list
		run_phase(20, 10, 10, 50);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("nearest_site_search_tb OK");
		else
			$display("nearest_site_search_tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/nss_pkg.sv
hdl/nearest_site_search.sv
verif/nearest_site_search_tb.sv
